// ----- hw/rtl/b128_pkg.sv -----
// Package for the binary128 add/multiply/compare unit.
// Types and constants used by the top module; no dependencies.
package b128_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_CMP = 2'd3;
  localparam logic [14:0] EXP_MAX = 15'h7FFF;
  localparam logic [14:0] EXP_BIAS = 15'h3FFF;
  localparam int unsigned ALIGN_LIMIT = 108;

  typedef struct packed {
    logic [1:0]   cmd;
    logic         sg;
    logic [16:0]  ex;
    logic [127:0] res;
    logic [2:0]   order;
    logic         done;
  } ctl_t;
endpackage

// ----- hw/rtl/b128_mul.sv -----
// Pipelined 113x113 mantissa multiplier: 16 partial products of 32x32 bits.
// Three register stages. Uses nothing from the package.
module b128_mul (
  input  logic         clk,
  input  logic [112:0] a,
  input  logic [112:0] b,
  output logic [225:0] p
);
  logic [127:0] ax, bx;
  logic [63:0]  pp_r [16];
  logic [255:0] row_r [4];
  logic [255:0] p_r;
  assign ax = {15'd0, a};
  assign bx = {15'd0, b};
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        pp_r[i*4+j] <= 64'(ax[i*32 +: 32]) * 64'(bx[j*32 +: 32]);
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      row_r[i] <= (256'(pp_r[i*4]) << (i*32)) + (256'(pp_r[i*4+1]) << (i*32+32))
                + (256'(pp_r[i*4+2]) << (i*32+64)) + (256'(pp_r[i*4+3]) << (i*32+96));
  end
  always_ff @(posedge clk) p_r <= row_r[0] + row_r[1] + row_r[2] + row_r[3];
  assign p = p_r[225:0];
endmodule

// ----- hw/rtl/binary128_add_mul_compare_top.sv -----
// binary128 add / subtract / multiply / compare unit, fully pipelined.
// Pipeline: four register stages, the first loaded at the accepting edge; out_valid
// is the last bit of the valid shift register and marks the result in the fourth stage.
// Throughput: one beat per cycle for all commands; busy is held low.
// The multiplier's three stages plus one pack stage set the depth; add and compare
// ride alongside. Reset (rst_n low, synchronous) clears the valid bits only; the
// receiver cannot stall, so each result shows for exactly one cycle.
module binary128_add_mul_compare_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_a_lo,
  input  logic [63:0] in_a_hi,
  input  logic [63:0] in_b_lo,
  input  logic [63:0] in_b_hi,
  input  logic        in_nan_ordered,
  output logic        out_valid,
  output logic [63:0] out_result_lo,
  output logic [63:0] out_result_hi,
  output logic signed [2:0] out_order
);
  logic [3:0] v_r;
  b128_pkg::ctl_t c1_r, c2_r, c3_r, c4_r, c1_nxt, c2_nxt, c4_nxt;
  logic [127:0] s1_r, s1_nxt; // add: raw sum or difference of aligned magnitudes
  logic [127:0] s3_r;
  logic [112:0] ma, mb;
  logic [225:0] prod;

  assign busy = 1'b0;

  // stage 1: decode, specials, align and add, multiply sign and exponent; compare fully resolved here
  logic [127:0] a, b, x, y;
  logic [14:0] ea, eb, ex;
  logic [15:0] d;
  logic [127:0] l1, l0;
  logic sx, sy;
  logic [127:0] an, bn;
  logic nan, mgt, meq;
  logic [2:0] m;
  always_comb begin
    a = {in_a_hi, in_a_lo};
    b = {in_b_hi ^ {(in_cmd == b128_pkg::CMD_SUB), 63'd0}, in_b_lo};
    ea = a[126:112];
    eb = b[126:112];
    ma = {1'b1, a[111:0]};
    mb = {1'b1, b[111:0]};
    c1_nxt = '0;
    c1_nxt.cmd = in_cmd;
    s1_nxt = '0;
    an = '0;
    bn = '0;
    nan = 1'b0;
    mgt = 1'b0;
    meq = 1'b0;
    m = '0;
    if (ea >= eb) begin
      x = a; y = b; ex = ea; d = {1'b0, ea - eb};
    end else begin
      x = b; y = a; ex = eb; d = {1'b0, eb - ea};
    end
    sx = x[127];
    sy = y[127];
    l1 = {16'd0, 1'b1, x[111:1]};
    l0 = (d + 16'd1 >= 16'd128) ? '0 : ({15'd0, 1'b1, y[111:0]} >> (d + 16'd1));
    c1_nxt.ex = {2'b0, ex};
    c1_nxt.sg = sx;
    unique case (in_cmd)
      b128_pkg::CMD_ADD, b128_pkg::CMD_SUB: begin
        if (ea == '0) begin
          c1_nxt.done = 1'b1; c1_nxt.res = b;
        end else if (eb == '0) begin
          c1_nxt.done = 1'b1; c1_nxt.res = a;
        end else if (d > 16'(b128_pkg::ALIGN_LIMIT)) begin
          c1_nxt.done = 1'b1; c1_nxt.res = x;
        end else if (sx == sy) begin
          s1_nxt = l1 + l0;
        end else if (l1 >= l0) begin
          s1_nxt = l1 - l0;
        end else begin
          s1_nxt = l0 - l1; c1_nxt.sg = ~sx;
        end
      end
      b128_pkg::CMD_MUL: begin
        c1_nxt.sg = a[127] ^ b[127];
        c1_nxt.ex = {2'b0, ea} + {2'b0, eb} - {2'b0, b128_pkg::EXP_BIAS};
        if (ea == '0 || eb == '0) begin
          c1_nxt.done = 1'b1; c1_nxt.res = {c1_nxt.sg, 127'd0};
        end
      end
      default: begin
        an = (ea == '0) ? '0 : a;
        bn = (in_b_hi[62:48] == '0) ? '0 : {in_b_hi, in_b_lo};
        nan = (an[126:112] == b128_pkg::EXP_MAX && an[111:0] != '0) ||
              (bn[126:112] == b128_pkg::EXP_MAX && bn[111:0] != '0);
        mgt = an[126:0] > bn[126:0];
        meq = an[126:0] == bn[126:0];
        m = meq ? 3'd0 : (mgt ? 3'd1 : 3'b111);
        c1_nxt.done = 1'b1;
        if (nan) c1_nxt.order = in_nan_ordered ? 3'd2 : 3'b110;
        else if (an[127] != bn[127]) c1_nxt.order = an[127] ? 3'b111 : 3'd1;
        else c1_nxt.order = an[127] ? 3'(-m) : m;
      end
    endcase
  end

  b128_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  // stage 2: leading-one search and normalise the sum
  logic [127:0] s2_r, s2_nxt;
  logic [6:0] p;
  logic found;
  always_comb begin
    c2_nxt = c1_r;
    p = '0;
    found = 1'b0;
    for (int i = 0; i < 113; i++)
      if (s1_r[i]) begin
        p = 7'(i); found = 1'b1;
      end
    s2_nxt = s1_r << (7'd112 - p);
    if (!c1_r.done && c1_r.cmd != b128_pkg::CMD_MUL) begin
      if (!found) begin
        c2_nxt.done = 1'b1; c2_nxt.res = '0;
      end else c2_nxt.ex = c1_r.ex + 17'd1 - 17'(7'd112 - p);
    end
  end

  // stage 4: multiply normalise and pack (stage 3 is a plain hold)
  logic [127:0] mant;
  logic [16:0] e;
  always_comb begin
    c4_nxt = c3_r;
    mant = s3_r;
    e = c3_r.ex;
    if (c3_r.cmd == b128_pkg::CMD_MUL) begin
      mant = 128'(prod[225:112]);
      if (mant[113]) begin
        mant = mant >> 1; e = e + 17'd1;
      end
    end
    if (!c3_r.done) begin
      if (!e[16] && e >= {2'b0, b128_pkg::EXP_MAX})
        c4_nxt.res = {c3_r.sg, b128_pkg::EXP_MAX, 112'd0};
      else if (e[16] || e == '0) c4_nxt.res = {c3_r.sg, 127'd0};
      else c4_nxt.res = {c3_r.sg, e[14:0], mant[111:0]};
    end
  end

  always_ff @(posedge clk) begin
    c1_r <= c1_nxt; s1_r <= s1_nxt;
    c2_r <= c2_nxt; s2_r <= s2_nxt;
    c3_r <= c2_r;   s3_r <= s2_r;
    c4_r <= c4_nxt;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[2:0], start};
  end

  assign out_valid = v_r[3];
  assign out_result_lo = (c4_r.cmd == b128_pkg::CMD_CMP) ? '0 : c4_r.res[63:0];
  assign out_result_hi = (c4_r.cmd == b128_pkg::CMD_CMP) ? '0 : c4_r.res[127:64];
  assign out_order = (c4_r.cmd == b128_pkg::CMD_CMP) ? c4_r.order : 3'd0;
endmodule
